/* src/ljpf_pkg.sv */
// Shared types and constants for the Lennard-Jones pair force accumulator.
package ljpf_pkg;

    localparam int unsigned ADDR_W = 6;

    localparam logic [ADDR_W-1:0] REG_BOX_X     = 6'h00;
    localparam logic [ADDR_W-1:0] REG_BOX_Y     = 6'h08;
    localparam logic [ADDR_W-1:0] REG_RM_SQ     = 6'h10;
    localparam logic [ADDR_W-1:0] REG_CUTOFF_SQ = 6'h18;
    localparam logic [ADDR_W-1:0] REG_EPS12     = 6'h20;

    // Pair entry handed from front to back end.
    typedef struct packed {
        logic        active;   // pair contributes (within cutoff, nonzero r2)
        logic        last;
        logic        dx_neg;
        logic        dy_neg;
        logic [31:0] adx;
        logic [31:0] ady;
        logic [63:0] r2;
    } pair_t;

    typedef struct packed {
        logic [31:0] rm_sq;
        logic [31:0] eps12;
    } coef_t;

endpackage

/* src/ljpf_front.sv */
// Front end: minimum-image wrap, r^2, cutoff test; emits one pair entry per item.
module ljpf_front import ljpf_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] target_x,
    input  logic [31:0] target_y,
    input  logic [31:0] other_x,
    input  logic [31:0] other_y,
    input  logic        other_valid,
    input  logic        last,
    input  logic [31:0] box_x,
    input  logic [31:0] box_y,
    input  logic [63:0] cutoff_sq,
    output logic        q_valid,
    input  logic        q_ready,
    output pair_t       q_data
);
    // stage 1: wrapped displacement
    logic        s1_valid_reg;
    logic        s1_ok_reg, s1_last_reg, s1_xn_reg, s1_yn_reg;
    logic [32:0] s1_ax_reg, s1_ay_reg;
    // stage 2: squares
    logic        s2_valid_reg;
    logic        s2_ok_reg, s2_last_reg, s2_xn_reg, s2_yn_reg;
    logic [31:0] s2_ax_reg, s2_ay_reg;
    logic [63:0] s2_sx_reg, s2_sy_reg;
    // output stage
    logic        q_valid_reg;
    pair_t       q_data_reg;

    logic adv1, adv2, adv3;
    assign adv3 = !q_valid_reg || q_ready;
    assign adv2 = !s2_valid_reg || adv3;
    assign adv1 = !s1_valid_reg || adv2;
    assign in_ready = adv1;

    function automatic logic [33:0] wrap(input logic [31:0] t, input logic [31:0] o,
                                         input logic [31:0] b);
        logic signed [34:0] d, d2, bs;
        begin
            d  = $signed({3'b000, t}) - $signed({3'b000, o});
            d2 = d <<< 1;
            bs = $signed({3'b000, b});
            if (d2 < -bs) d = d + bs;
            else if (d2 > bs) d = d - bs;
            wrap = d[33:0];
        end
    endfunction

    logic [33:0] dx, dy, adx, ady;
    always_comb begin
        dx  = wrap(target_x, other_x, box_x);
        dy  = wrap(target_y, other_y, box_y);
        adx = dx[33] ? 34'(-dx) : dx;
        ady = dy[33] ? 34'(-dy) : dy;
    end

    logic [64:0] r2w;
    assign r2w = {1'b0, s2_sx_reg} + {1'b0, s2_sy_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            q_valid_reg  <= 1'b0;
        end else begin
            if (adv1) s1_valid_reg <= in_valid;
            if (adv2) s2_valid_reg <= s1_valid_reg;
            if (adv3) q_valid_reg  <= s2_valid_reg;
        end
        if (adv1) begin
            s1_ok_reg   <= other_valid && (adx[33:32] == 2'b00) && (ady[33:32] == 2'b00);
            s1_last_reg <= last;
            s1_xn_reg   <= dx[33];
            s1_yn_reg   <= dy[33];
            s1_ax_reg   <= adx[32:0];
            s1_ay_reg   <= ady[32:0];
        end
        if (adv2) begin
            s2_ok_reg   <= s1_ok_reg;
            s2_last_reg <= s1_last_reg;
            s2_xn_reg   <= s1_xn_reg;
            s2_yn_reg   <= s1_yn_reg;
            s2_ax_reg   <= s1_ax_reg[31:0];
            s2_ay_reg   <= s1_ay_reg[31:0];
            s2_sx_reg   <= s1_ax_reg[31:0] * s1_ax_reg[31:0];
            s2_sy_reg   <= s1_ay_reg[31:0] * s1_ay_reg[31:0];
        end
        if (adv3) begin
            q_data_reg.active <= s2_ok_reg && !r2w[64] && (r2w[63:0] < cutoff_sq)
                                 && (r2w[63:0] != 64'd0);
            q_data_reg.last   <= s2_last_reg;
            q_data_reg.dx_neg <= s2_xn_reg;
            q_data_reg.dy_neg <= s2_yn_reg;
            q_data_reg.adx    <= s2_ax_reg;
            q_data_reg.ady    <= s2_ay_reg;
            q_data_reg.r2     <= r2w[63:0];
        end
    end

    assign q_valid = q_valid_reg;
    assign q_data  = q_data_reg;
endmodule

/* src/ljpf_fifo.sv */
// Short queue between front and back ends.
module ljpf_fifo import ljpf_pkg::*; #(
    parameter int unsigned DEPTH = 4
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  wr_valid,
    output logic  wr_ready,
    input  pair_t wr_data,
    output logic  rd_valid,
    input  logic  rd_ready,
    output pair_t rd_data
);
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    pair_t         mem_reg [DEPTH];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [AW:0]   cnt_reg;
    logic          wr, rd;

    assign wr_ready = (cnt_reg != (AW+1)'(DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign wr = wr_valid && wr_ready;
    assign rd = rd_valid && rd_ready;
    assign rd_data = mem_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (wr) wp_reg <= (wp_reg == AW'(DEPTH-1)) ? '0 : wp_reg + AW'(1);
            if (rd) rp_reg <= (rp_reg == AW'(DEPTH-1)) ? '0 : rp_reg + AW'(1);
            cnt_reg <= cnt_reg + (AW+1)'(wr) - (AW+1)'(rd);
        end
        if (wr) mem_reg[wp_reg] <= wr_data;
    end
endmodule

/* src/ljpf_div.sv */
// Radix-2 restoring divider: floor({hi,lo}/den), one quotient bit per cycle.
module ljpf_div (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [127:0] num,
    input  logic [63:0]  den,
    output logic         done,
    output logic [63:0]  quot,
    output logic         clip
);
    logic [63:0] rem_reg, lo_reg, q_reg;
    logic [6:0]  cnt_reg;
    logic        busy_reg, done_reg, clip_reg;
    logic [64:0] sh;
    logic        ge;

    assign sh = {rem_reg, lo_reg[63]};
    assign ge = (sh >= {1'b0, den});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            // quotient overflow finishes at once with a saturated result
            done_reg <= start ? (num[127:64] >= den) : (busy_reg && cnt_reg == 7'd63);
            busy_reg <= start ? (num[127:64] < den) : (busy_reg && cnt_reg != 7'd63);
        end
        if (start) begin
            rem_reg  <= num[127:64];
            lo_reg   <= num[63:0];
            q_reg    <= '1;
            cnt_reg  <= '0;
            clip_reg <= (num[127:64] >= den);
        end else if (busy_reg) begin
            rem_reg <= ge ? 64'(sh - {1'b0, den}) : sh[63:0];
            lo_reg  <= {lo_reg[62:0], 1'b0};
            q_reg   <= {q_reg[62:0], ge};
            cnt_reg <= cnt_reg + 7'd1;
        end
    end

    assign done = done_reg;
    assign quot = q_reg;
    assign clip = clip_reg;
endmodule

/* src/ljpf_back.sv */
// Back end: sequencer for s^2, powers, force ratio, terms and saturating sums.
module ljpf_back import ljpf_pkg::*; #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         q_valid,
    output logic         q_ready,
    input  pair_t        q_data,
    input  coef_t        coef,
    output logic         m_valid,
    input  logic         m_ready,
    output logic [63:0]  force_x,
    output logic [63:0]  force_y,
    output logic         saturated
);
    localparam logic [63:0] SMAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] SMIN = 64'h8000_0000_0000_0000;

    typedef enum logic [3:0] {
        ST_IDLE, ST_DIV1, ST_WAIT1, ST_P1, ST_P2, ST_P3, ST_DIFF, ST_FR,
        ST_DIV2, ST_WAIT2, ST_TX, ST_TY, ST_EMIT
    } state_t;

    state_t      state_reg;
    pair_t       pr_reg;
    logic [63:0] s2_reg, s6_reg, mag_reg, fr_reg, term_reg;
    logic [63:0] sum_x_reg, sum_y_reg;
    logic        clip_seen_reg, clip_reg, neg_reg, c12_reg, tph_reg;
    logic        m_valid_reg;
    logic [63:0] out_x_reg, out_y_reg;
    logic        out_sat_reg;

    // shared multiplier: four 32x32 partial products, one per cycle
    logic [63:0]  ma_reg, mb_reg;
    logic [127:0] prod_reg;
    logic [1:0]   mcnt_reg;
    logic         mgo_reg, mbusy_reg, mdone_reg;
    logic [31:0]  pa, pb;
    logic [63:0]  pp;
    logic [127:0] pp_sh;
    logic         mul_load;

    always_comb begin
        pa = mcnt_reg[0] ? ma_reg[63:32] : ma_reg[31:0];
        pb = mcnt_reg[1] ? mb_reg[63:32] : mb_reg[31:0];
        pp = 64'(pa) * 64'(pb);
        case (mcnt_reg)
            2'd0:    pp_sh = {64'd0, pp};
            2'd3:    pp_sh = {pp, 64'd0};
            default: pp_sh = {32'd0, pp, 32'd0};
        endcase
    end

    logic         dv_start, dv_done, dv_clip;
    logic [127:0] dv_num;
    logic [63:0]  dv_quot;

    ljpf_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(dv_start), .num(dv_num),
        .den(pr_reg.r2), .done(dv_done), .quot(dv_quot), .clip(dv_clip)
    );

    assign dv_start = (state_reg == ST_DIV1) || (state_reg == ST_DIV2);
    assign dv_num = (state_reg == ST_DIV1) ? (128'(coef.rm_sq) << (3*FRAC_BITS))
                                           : (prod_reg << FRAC_BITS);

    logic [127:0] shp;
    logic [127:0] shq;
    logic         shp_ovf;
    assign shp = prod_reg >> (2*FRAC_BITS);
    assign shp_ovf = (shp[127:64] != '0);
    assign shq = prod_reg >> FRAC_BITS;

    // operands are loaded into ma/mb on these edges; the multiply starts next cycle
    assign mul_load = ((state_reg == ST_WAIT1) && dv_done)
                   || ((state_reg == ST_P1) && mdone_reg)
                   || ((state_reg == ST_P2) && mdone_reg)
                   || (state_reg == ST_DIFF)
                   || ((state_reg == ST_WAIT2) && dv_done)
                   || ((state_reg == ST_TX) && tph_reg);

    // term magnitude and sign
    logic        tneg, dneg;
    logic [63:0] tlim, tmag, term;
    logic        tclip;
    always_comb begin
        dneg  = (state_reg == ST_TY) ? pr_reg.dy_neg : pr_reg.dx_neg;
        tneg  = neg_reg != dneg;
        tlim  = tneg ? SMIN : SMAX;
        tclip = (shq[127:64] != '0) || (shq[63:0] > tlim);
        tmag  = tclip ? tlim : shq[63:0];
        term  = tneg ? 64'(-tmag) : tmag;
    end

    function automatic logic [64:0] sadd(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] s;
        begin
            s = a + b;
            if (((a ^ b) & SMIN) == '0 && ((s ^ a) & SMIN) != '0)
                sadd = {1'b1, a[63] ? SMIN : SMAX};
            else
                sadd = {1'b0, s};
        end
    endfunction

    logic [64:0] add_res;
    assign add_res = sadd((state_reg == ST_TY) ? sum_y_reg : sum_x_reg, term_reg);

    assign q_ready = (state_reg == ST_IDLE) && !(m_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            sum_x_reg     <= '0;
            sum_y_reg     <= '0;
            clip_seen_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
            tph_reg       <= 1'b0;
            mgo_reg       <= 1'b0;
            mbusy_reg     <= 1'b0;
            mdone_reg     <= 1'b0;
            mcnt_reg      <= '0;
        end else begin
            // multiplier sequencing
            mgo_reg   <= mul_load;
            mdone_reg <= mbusy_reg && (mcnt_reg == 2'd3);
            if (mgo_reg) mbusy_reg <= 1'b1;
            else if (mbusy_reg && mcnt_reg == 2'd3) mbusy_reg <= 1'b0;
            if (mgo_reg || mbusy_reg) begin
                mcnt_reg <= mcnt_reg + 2'd1;
                prod_reg <= (mgo_reg ? 128'd0 : prod_reg) + pp_sh;
            end

            if (m_valid_reg && m_ready) m_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE: begin
                    if (q_valid && q_ready) begin
                        pr_reg   <= q_data;
                        clip_reg <= 1'b0;
                        state_reg <= q_data.active ? ST_DIV1 : ST_EMIT;
                    end
                end
                ST_DIV1: state_reg <= ST_WAIT1;
                ST_WAIT1: begin
                    if (dv_done) begin
                        s2_reg   <= dv_quot;
                        clip_reg <= clip_reg | dv_clip;
                        ma_reg   <= dv_quot;
                        mb_reg   <= dv_quot;
                        state_reg <= ST_P1;
                    end
                end
                ST_P1: begin
                    if (mdone_reg) begin
                        s6_reg   <= shp_ovf ? '1 : shp[63:0];
                        clip_reg <= clip_reg | shp_ovf;
                        ma_reg   <= shp_ovf ? '1 : shp[63:0];
                        mb_reg   <= s2_reg;
                        state_reg <= ST_P2;
                    end
                end
                ST_P2: begin
                    if (mdone_reg) begin
                        s6_reg   <= shp_ovf ? '1 : shp[63:0];
                        clip_reg <= clip_reg | shp_ovf;
                        ma_reg   <= shp_ovf ? '1 : shp[63:0];
                        mb_reg   <= shp_ovf ? '1 : shp[63:0];
                        state_reg <= ST_P3;
                    end
                end
                ST_P3: begin
                    if (mdone_reg) begin
                        c12_reg  <= shp_ovf;
                        mag_reg  <= shp[63:0];
                        state_reg <= ST_DIFF;
                    end
                end
                ST_DIFF: begin
                    if (c12_reg) begin
                        clip_reg <= 1'b1;
                        neg_reg  <= 1'b0;
                        mb_reg   <= '1;
                    end else begin
                        neg_reg <= mag_reg < s6_reg;
                        mb_reg  <= (mag_reg < s6_reg) ? s6_reg - mag_reg : mag_reg - s6_reg;
                    end
                    ma_reg    <= {32'd0, coef.eps12};
                    state_reg <= ST_FR;
                end
                ST_FR: begin
                    if (mdone_reg) state_reg <= ST_DIV2;
                end
                ST_DIV2: state_reg <= ST_WAIT2;
                ST_WAIT2: begin
                    if (dv_done) begin
                        fr_reg   <= dv_quot;
                        clip_reg <= clip_reg | dv_clip;
                        ma_reg   <= dv_quot;
                        mb_reg   <= {32'd0, pr_reg.adx};
                        state_reg <= ST_TX;
                    end
                end
                ST_TX: begin
                    // product ready: form the term, then add it
                    if (tph_reg) begin
                        sum_x_reg <= add_res[63:0];
                        clip_reg  <= clip_reg | add_res[64];
                        ma_reg    <= fr_reg;
                        mb_reg    <= {32'd0, pr_reg.ady};
                        tph_reg   <= 1'b0;
                        state_reg <= ST_TY;
                    end else if (mdone_reg) begin
                        term_reg <= term;
                        clip_reg <= clip_reg | tclip;
                        tph_reg  <= 1'b1;
                    end
                end
                ST_TY: begin
                    if (tph_reg) begin
                        sum_y_reg <= add_res[63:0];
                        clip_reg  <= clip_reg | add_res[64];
                        tph_reg   <= 1'b0;
                        state_reg <= ST_EMIT;
                    end else if (mdone_reg) begin
                        term_reg <= term;
                        clip_reg <= clip_reg | tclip;
                        tph_reg  <= 1'b1;
                    end
                end
                ST_EMIT: begin
                    if (pr_reg.last) begin
                        out_x_reg     <= sum_x_reg;
                        out_y_reg     <= sum_y_reg;
                        out_sat_reg   <= clip_seen_reg | clip_reg;
                        m_valid_reg   <= 1'b1;
                        sum_x_reg     <= '0;
                        sum_y_reg     <= '0;
                        clip_seen_reg <= 1'b0;
                    end else begin
                        clip_seen_reg <= clip_seen_reg | clip_reg;
                    end
                    state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid   = m_valid_reg;
    assign force_x   = out_x_reg;
    assign force_y   = out_y_reg;
    assign saturated = out_sat_reg;
endmodule

/* src/lj_pair_force_accumulate.sv */
// Top level: APB registers, front end, pair queue and back-end sequencer.
// A skipped or empty last item takes the short path to a result; an in-cutoff one passes
// through two 64-step divides and six multiplies.
// The front takes one transaction a cycle, unless the queue is full, into a 4-entry queue;
// the back end handles one pair at a time and takes the next only when back in idle.
// Reset (aresetn low, synchronous) clears sums, flag, queue and restores register defaults.
module lj_pair_force_accumulate import ljpf_pkg::*; #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [5:0]    paddr,
    input  logic [63:0]   pwdata,
    output logic [63:0]   prdata,
    output logic          pready,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [127:0]  s_tdata,  // target_x, target_y, other_x, other_y
    input  logic          s_tuser,  // other_valid
    input  logic          s_tlast,  // last
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [127:0]  m_tdata,  // force_x, force_y
    output logic          m_tuser   // saturated
);
    logic [31:0] box_x_reg, box_y_reg, rm_sq_reg, eps_reg;
    logic [63:0] cut_reg;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            box_x_reg <= 32'd65536;
            box_y_reg <= 32'd65536;
            rm_sq_reg <= 32'd164;
            cut_reg   <= 64'd0;
            eps_reg   <= 32'd3932160;
        end else if (wr_en) begin
            case (paddr)
                REG_BOX_X:     box_x_reg <= pwdata[31:0];
                REG_BOX_Y:     box_y_reg <= pwdata[31:0];
                REG_RM_SQ:     rm_sq_reg <= pwdata[31:0];
                REG_CUTOFF_SQ: cut_reg   <= pwdata;
                REG_EPS12:     eps_reg   <= pwdata[31:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr)
            REG_BOX_X:     prdata = {32'd0, box_x_reg};
            REG_BOX_Y:     prdata = {32'd0, box_y_reg};
            REG_RM_SQ:     prdata = {32'd0, rm_sq_reg};
            REG_CUTOFF_SQ: prdata = cut_reg;
            REG_EPS12:     prdata = {32'd0, eps_reg};
            default:       prdata = '0;
        endcase
    end

    logic  f_valid, f_ready, b_valid, b_ready;
    pair_t f_data, b_data;
    coef_t coef;
    assign coef.rm_sq = rm_sq_reg;
    assign coef.eps12 = eps_reg;

    ljpf_front u_front (
        .aclk(aclk), .aresetn(aresetn), .in_valid(s_tvalid), .in_ready(s_tready),
        .target_x(s_tdata[31:0]), .target_y(s_tdata[63:32]),
        .other_x(s_tdata[95:64]), .other_y(s_tdata[127:96]),
        .other_valid(s_tuser), .last(s_tlast),
        .box_x(box_x_reg), .box_y(box_y_reg), .cutoff_sq(cut_reg),
        .q_valid(f_valid), .q_ready(f_ready), .q_data(f_data)
    );

    ljpf_fifo #(.DEPTH(4)) u_fifo (
        .aclk(aclk), .aresetn(aresetn),
        .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_data),
        .rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_data)
    );

    ljpf_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(b_valid), .q_ready(b_ready), .q_data(b_data), .coef(coef),
        .m_valid(m_tvalid), .m_ready(m_tready),
        .force_x(m_tdata[63:0]), .force_y(m_tdata[127:64]), .saturated(m_tuser)
    );
endmodule

/* dv/testbench.sv */
// Testbench for the Lennard-Jones pair force accumulator: directed and random stream checks.
`timescale 1ns / 1ps

module testbench;
    import ljpf_pkg::*;

    localparam logic [63:0] U64_MAX = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] S64_MIN = 64'h8000_0000_0000_0000;
    localparam int          FB      = 16;
    localparam int          SETTLE  = 2000;  // front + queue + back end, with margin

    typedef struct {
        logic [63:0] force_x;
        logic [63:0] force_y;
        logic        saturated;
    } force_sum_t;

    logic          aclk = 1'b0;
    logic          aresetn = 1'b0;
    logic          psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [5:0]    paddr = '0;
    logic [63:0]   pwdata = '0;
    logic [63:0]   prdata;
    logic          pready;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    logic [127:0]  s_tdata = '0;   // target_x, target_y, other_x, other_y
    logic          s_tuser = 1'b0; // other_valid
    logic          s_tlast = 1'b0; // last
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    logic [127:0]  m_tdata;        // force_x, force_y
    logic          m_tuser;        // saturated

    lj_pair_force_accumulate dut (.*);

    initial begin
        forever #1 aclk = ~aclk;
    end

    // predictor state and register copies
    logic [31:0] box_x_q = 32'd65536, box_y_q = 32'd65536, rm_sq_q = 32'd164;
    logic [63:0] cutoff_q = '0;
    logic [31:0] eps12_q = 32'd3932160;
    logic [63:0] acc_fx = '0, acc_fy = '0;
    logic        acc_clip = 1'b0;

    force_sum_t  expected_sums[$];
    bit          idle_on = 1'b1;
    int          errors = 0;
    int          items_sent = 0;
    int          sums_seen = 0;
    int          pairs_in_range = 0;

    function automatic logic [63:0] clamp(logic [127:0] x, logic [63:0] lim, inout bit clip);
        if (x > {64'd0, lim}) begin
            clip = 1'b1;
            return lim;
        end
        return x[63:0];
    endfunction

    function automatic logic [63:0] quot(logic [127:0] num, logic [63:0] den, inout bit clip);
        logic [127:0] q;
        if (num[127:64] >= den) begin
            clip = 1'b1;
            return U64_MAX;
        end
        q = num / {64'd0, den};
        return q[63:0];
    endfunction

    function automatic longint min_image(logic [31:0] t, logic [31:0] o, logic [31:0] box);
        longint d, b;
        d = longint'({32'd0, t}) - longint'({32'd0, o});
        b = longint'({32'd0, box});
        if (2 * d < -b) d += b;
        else if (2 * d > b) d -= b;
        return d;
    endfunction

    function automatic logic [63:0] axis_term(logic [63:0] fr, longint d, bit dneg_diff,
                                              inout bit clip);
        logic [63:0]  ad, mag;
        logic [127:0] p;
        bit           neg;
        ad  = (d < 0) ? -d : d;
        neg = dneg_diff != (d < 0);
        p   = ({64'd0, fr} * {64'd0, ad}) >> FB;
        mag = clamp(p, neg ? S64_MIN : S64_MAX, clip);
        return neg ? -mag : mag;
    endfunction

    function automatic logic [63:0] add_sat(logic [63:0] a, logic [63:0] b, inout bit clip);
        logic [63:0] s;
        s = a + b;
        if (a[63] == b[63] && s[63] != a[63]) begin
            clip = 1'b1;
            return a[63] ? S64_MIN : S64_MAX;
        end
        return s;
    endfunction

    function automatic void accumulate_pair(logic [31:0] tx, logic [31:0] ty,
                                            logic [31:0] ox, logic [31:0] oy);
        bit          clip, c12, neg;
        longint      dx, dy;
        logic [63:0] adx, ady, sx, r2, s2, s6, s12, mag, fr, tx_f, ty_f;
        clip = 0;
        c12  = 0;
        dx   = min_image(tx, ox, box_x_q);
        dy   = min_image(ty, oy, box_y_q);
        adx  = (dx < 0) ? -dx : dx;
        ady  = (dy < 0) ? -dy : dy;
        if (adx > 64'hFFFF_FFFF || ady > 64'hFFFF_FFFF) return;
        sx = adx * adx;
        r2 = sx + ady * ady;
        if (r2 < sx || r2 >= cutoff_q || r2 == 0) return;
        pairs_in_range++;
        s2  = quot({96'd0, rm_sq_q} << (3 * FB), r2, clip);
        s6  = clamp(({64'd0, s2} * {64'd0, s2}) >> (2 * FB), U64_MAX, clip);
        s6  = clamp(({64'd0, s6} * {64'd0, s2}) >> (2 * FB), U64_MAX, clip);
        s12 = clamp(({64'd0, s6} * {64'd0, s6}) >> (2 * FB), U64_MAX, c12);
        if (c12) begin
            clip = 1'b1;
            neg  = 1'b0;
            mag  = U64_MAX;
        end else begin
            neg = s12 < s6;
            mag = neg ? s6 - s12 : s12 - s6;
        end
        fr   = quot(({96'd0, eps12_q} * {64'd0, mag}) << FB, r2, clip);
        tx_f = axis_term(fr, dx, neg, clip);
        ty_f = axis_term(fr, dy, neg, clip);
        acc_fx = add_sat(acc_fx, tx_f, clip);
        acc_fy = add_sat(acc_fy, ty_f, clip);
        if (clip) acc_clip = 1'b1;
    endfunction

    function automatic void predict_item(logic [127:0] data, logic ov, logic lst);
        force_sum_t r;
        if (ov) accumulate_pair(data[31:0], data[63:32], data[95:64], data[127:96]);
        if (lst) begin
            r.force_x   = acc_fx;
            r.force_y   = acc_fy;
            r.saturated = acc_clip;
            expected_sums.insert(expected_sums.size(), r);
            acc_fx   = '0;
            acc_fy   = '0;
            acc_clip = 1'b0;
        end
    endfunction

    task automatic reg_write(logic [5:0] addr, logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        case (addr)
            REG_BOX_X:     box_x_q  = value[31:0];
            REG_BOX_Y:     box_y_q  = value[31:0];
            REG_RM_SQ:     rm_sq_q  = value[31:0];
            REG_CUTOFF_SQ: cutoff_q = value;
            REG_EPS12:     eps12_q  = value[31:0];
            default: ;
        endcase
    endtask

    task automatic set_regs(logic [31:0] bx, logic [31:0] by, logic [31:0] rm,
                            logic [63:0] cut, logic [31:0] e12);
        reg_write(REG_BOX_X, {32'd0, bx});
        reg_write(REG_BOX_Y, {32'd0, by});
        reg_write(REG_RM_SQ, {32'd0, rm});
        reg_write(REG_CUTOFF_SQ, cut);
        reg_write(REG_EPS12, {32'd0, e12});
    endtask

    task automatic send_pair(logic [31:0] tx, logic [31:0] ty, logic [31:0] ox,
                             logic [31:0] oy, logic ov, logic lst);
        if (idle_on && $urandom_range(0, 6) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {oy, ox, ty, tx};
        s_tuser  <= ov;
        s_tlast  <= lst;
        do @(posedge aclk); while (!s_tready);
        predict_item({oy, ox, ty, tx}, ov, lst);
        items_sent++;
    endtask

    // drops valid, waits for all sums and lets skipped work drain
    task automatic drain;
        s_tvalid <= 1'b0;
        while (expected_sums.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // one target against a short neighbour list, mostly close by
    task automatic send_neighbour_list;
        logic [31:0] tx, ty, ox, oy;
        int          n;
        n  = $urandom_range(1, 7);
        tx = $urandom_range(0, box_x_q);
        ty = $urandom_range(0, box_y_q);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) == 0) begin
                ox = $urandom();
                oy = $urandom();
            end else begin
                ox = tx + $urandom_range(0, 6 << FB) - (3 << FB);
                oy = ty + $urandom_range(0, 6 << FB) - (3 << FB);
            end
            send_pair(tx, ty, ox, oy, $urandom_range(0, 7) != 0, i == n - 1);
        end
    endtask

    task automatic test_reset_defaults;
        // zero cutoff: every pair is skipped, sums stay zero
        for (int i = 0; i < 4; i++)
            send_pair($urandom(), $urandom(), $urandom(), $urandom(), 1'b1, i[0]);
        drain();
    endtask

    task automatic test_directed;
        set_regs(32'd10 << FB, 32'd10 << FB, 32'd1 << FB, 64'd9 << 32, 32'd12 << FB);
        send_pair(32'h8000, 32'h8000, 32'h8000, 32'h8000, 1'b1, 1'b1);        // coincident
        send_pair(32'h8000, 32'h1_0000, 32'h9_8000, 32'h1_0000, 1'b1, 1'b0); // wrap x
        send_pair(32'h2_0000, 32'h9_8000, 32'h2_0000, 32'h8000, 1'b1, 1'b1); // wrap y
        send_pair(32'h1_0000, 32'h1_0000, 32'h1_0001, 32'h1_0000, 1'b1, 1'b1); // huge s^12
        send_pair(32'h1_0000, 32'h1_0000, 32'h1_C000, 32'h1_4000, 1'b1, 1'b1); // repulsive
        send_pair(32'h1_0000, 32'h1_0000, 32'h1_0000, 32'h1_0000, 1'b0, 1'b1); // empty list
        send_pair(32'h0, 32'h0, 32'h5_0000, 32'h0, 1'b1, 1'b1);               // beyond cutoff
        drain();
        // extreme registers
        set_regs(32'd1, U64_MAX[31:0], U64_MAX[31:0], U64_MAX, U64_MAX[31:0]);
        send_pair(32'h0, 32'h0, U64_MAX[31:0], U64_MAX[31:0], 1'b1, 1'b1);    // far pair
        send_pair(32'h0, 32'h0, 32'h1, 32'h1, 1'b1, 1'b0);
        send_pair(32'h0, 32'h0, 32'h3, 32'h0, 1'b1, 1'b0);
        send_pair(32'h0, 32'h0, 32'h0, 32'h7, 1'b1, 1'b1);                   // sums clip
        send_pair(U64_MAX[31:0], 32'h0, 32'h0, U64_MAX[31:0], 1'b1, 1'b1);
        drain();
        set_regs(U64_MAX[31:0], 32'd1, 32'd0, U64_MAX, 32'd0);
        send_pair(32'h1234_5678, 32'h0, 32'h1234_0000, 32'h0, 1'b1, 1'b1);
        send_pair(32'h0, 32'h0, 32'h8000_0000, 32'h0, 1'b1, 1'b1);
        send_pair(32'h0, 32'h0, 32'h8000_0001, 32'h0, 1'b1, 1'b1);
        drain();
    endtask

    task automatic test_random_phases(int phases, int lists);
        logic [31:0] bx, by;
        for (int p = 0; p < phases; p++) begin
            bx = $urandom_range(4, 40) << FB;
            by = $urandom_range(4, 40) << FB;
            if ($urandom_range(0, 4) == 0) bx = $urandom();
            if (bx == 0) bx = 1;
            set_regs(bx, by, $urandom_range(1 << 14, 3 << FB),
                     {$urandom_range(0, 12), $urandom()},
                     ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 2000 << FB));
            for (int i = 0; i < lists; i++) begin
                if ($urandom_range(0, 11) == 0)
                    send_pair($urandom(), $urandom(), $urandom(), $urandom(),
                              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                else
                    send_neighbour_list();
            end
            drain();
        end
    endtask

    // sink back-pressure
    initial begin
        forever begin
            if (idle_on && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge aclk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        force_sum_t e;
        if (aresetn && m_tvalid && m_tready) begin
            sums_seen++;
            if (expected_sums.size() == 0) begin
                $error("unexpected result transaction");
                errors++;
            end else begin
                e = expected_sums.pop_front();
                if (m_tdata[63:0] !== e.force_x) begin
                    $error("force_x expected %h actual %h", e.force_x, m_tdata[63:0]);
                    errors++;
                end
                if (m_tdata[127:64] !== e.force_y) begin
                    $error("force_y expected %h actual %h", e.force_y, m_tdata[127:64]);
                    errors++;
                end
                if (m_tuser !== e.saturated) begin
                    $error("saturated expected %b actual %b", e.saturated, m_tuser);
                    errors++;
                end
            end
        end
    end

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_defaults();
        test_directed();
        test_random_phases(7, 48);
        idle_on = 1'b0;
        test_random_phases(1, 48);
        if (expected_sums.size() != 0) begin
            $error("%0d results never arrived", expected_sums.size());
            errors++;
        end
        $display("Run covered %0d input items, %0d in-range pairs, %0d force results.",
                 items_sent, pairs_in_range, sums_seen);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #8_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
